@@ src/pblru_pkg.sv @@
// Shared types and constants of the page buffer LRU tag controller.
`default_nettype none

package pblru_pkg;

    localparam int NUM_SLOTS_DEF    = 16;
    localparam int FILE_ID_BITS_DEF = 8;

    localparam int ACTION_W  = 2;
    localparam int FILE_W    = 8;
    localparam int PAGE_W    = 32;
    localparam int SLOT_W    = 4;

    localparam logic [ACTION_W-1:0] ACT_FETCH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DIRTY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic run_fetch;
        logic run_dirty;
        logic run_flush;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush_last;
    } t_dp_status;

endpackage

`default_nettype wire

@@ src/pblru_ctrl.sv @@
// Request sequencer of the page buffer LRU tag controller.
`default_nettype none

module pblru_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [pblru_pkg::ACTION_W-1:0]    i_action,
    input  wire pblru_pkg::t_dp_status             i_status,
    output pblru_pkg::t_dp_cmd                     o_cmd,
    output logic                                   o_busy
);
    import pblru_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIRTY,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_FETCH: n_state = S_FETCH;
                        ACT_DIRTY: n_state = S_DIRTY;
                        ACT_FLUSH: n_state = S_FLUSH;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: n_state = S_IDLE;
            S_DIRTY: n_state = S_IDLE;
            S_FLUSH: begin
                if (i_status.flush_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_cmd.capture     = i_start && (r_state == S_IDLE);
    assign o_cmd.run_fetch   = (r_state == S_FETCH);
    assign o_cmd.run_dirty   = (r_state == S_DIRTY);
    assign o_cmd.run_flush   = (r_state == S_FLUSH);

endmodule

`default_nettype wire

@@ src/pblru_datapath.sv @@
// Tag store, recency ranks and result registers of the page buffer LRU tag controller.
`default_nettype none

module pblru_datapath #(
    parameter int NUM_SLOTS    = pblru_pkg::NUM_SLOTS_DEF,
    parameter int FILE_ID_BITS = pblru_pkg::FILE_ID_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pblru_pkg::t_dp_cmd              i_cmd,
    output pblru_pkg::t_dp_status                o_status,
    input  wire logic [pblru_pkg::FILE_W-1:0]    i_file_id,
    input  wire logic [pblru_pkg::PAGE_W-1:0]    i_page_number,
    output logic                                 o_strobe,
    output logic [pblru_pkg::SLOT_W-1:0]         o_slot,
    output logic                                 o_matched,
    output logic                                 o_load_needed,
    output logic                                 o_writeback,
    output logic [pblru_pkg::FILE_W-1:0]         o_writeback_file,
    output logic [pblru_pkg::PAGE_W-1:0]         o_writeback_page,
    output logic                                 o_last
);
    import pblru_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0] NEWEST = IW'(NUM_SLOTS - 1);

    // Slot state.
    logic [NUM_SLOTS-1:0]    r_valid;
    logic [NUM_SLOTS-1:0]    r_dirty;
    logic [FILE_ID_BITS-1:0] r_file [NUM_SLOTS];
    logic [PAGE_W-1:0]       r_page [NUM_SLOTS];
    logic [IW-1:0]           r_rank [NUM_SLOTS];

    // Captured request and its tag match vector.
    logic [NUM_SLOTS-1:0]    r_hit;
    logic [FILE_ID_BITS-1:0] r_req_file;
    logic [PAGE_W-1:0]       r_req_page;

    // Result registers.
    logic                    r_strobe;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_matched;
    logic                    r_load;
    logic                    r_wb;
    logic [FILE_W-1:0]       r_wb_file;
    logic [PAGE_W-1:0]       r_wb_page;
    logic                    r_last;

    logic                    n_strobe;
    logic [SLOT_W-1:0]       n_slot;
    logic                    n_matched;
    logic                    n_load;
    logic                    n_wb;
    logic [FILE_W-1:0]       n_wb_file;
    logic [PAGE_W-1:0]       n_wb_page;
    logic                    n_last;

    logic [FILE_ID_BITS+FILE_W-1:0] in_file_ext;
    logic [FILE_ID_BITS-1:0]        in_file;
    logic [NUM_SLOTS-1:0]           hit_vec;
    logic [NUM_SLOTS-1:0]           rank_zero;
    logic                           hit_any;
    logic                           free_any;
    logic                           evict;
    logic                           wb_victim;
    logic [IW-1:0]                  hit_idx;
    logic [IW-1:0]                  free_idx;
    logic [IW-1:0]                  victim_idx;
    logic [IW-1:0]                  fl_idx;
    logic [IW-1:0]                  target_idx;
    logic [IW-1:0]                  rd_idx;
    logic [IW-1:0]                  out_idx;
    logic [IW+SLOT_W-1:0]           out_idx_ext;
    logic [FILE_ID_BITS-1:0]        rd_file;
    logic [FILE_ID_BITS+FILE_W-1:0] rd_file_ext;
    logic [PAGE_W-1:0]              rd_page;
    logic [NUM_SLOTS-1:0]           fl_rem;
    logic [IW-1:0]                  target_rank;

    // Only the low FILE_ID_BITS of the file id take part in the tag.
    assign in_file_ext = {{FILE_ID_BITS{1'b0}}, i_file_id};
    assign in_file     = in_file_ext[FILE_ID_BITS-1:0];

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            hit_vec[i]   = r_valid[i] && (r_file[i] == in_file)
                           && (r_page[i] == i_page_number);
            rank_zero[i] = (r_rank[i] == '0);
        end
    end

    // Lowest-index encoders over the slot vectors.
    always_comb begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        fl_idx     = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
            if (rank_zero[i]) begin
                victim_idx = IW'(i);
            end
            if (r_dirty[i]) begin
                fl_idx = IW'(i);
            end
        end
    end

    assign hit_any    = |r_hit;
    assign free_any   = ~&r_valid;
    assign evict      = !hit_any && !free_any;
    assign wb_victim  = evict && r_dirty[victim_idx];
    assign target_idx = hit_any ? hit_idx : (free_any ? free_idx : victim_idx);
    assign target_rank = r_rank[target_idx];

    // A single read port serves both the eviction and the flush.
    assign rd_idx      = i_cmd.run_flush ? fl_idx : victim_idx;
    assign rd_file     = r_file[rd_idx];
    assign rd_page     = r_page[rd_idx];
    assign rd_file_ext = {{FILE_W{1'b0}}, rd_file};

    assign fl_rem = r_dirty & ~({{(NUM_SLOTS-1){1'b0}}, 1'b1} << fl_idx);
    assign o_status.flush_last = (fl_rem == '0);

    always_comb begin
        out_idx = '0;
        if (i_cmd.run_fetch) begin
            out_idx = target_idx;
        end else if (i_cmd.run_dirty) begin
            out_idx = hit_any ? hit_idx : '0;
        end else if (i_cmd.run_flush) begin
            out_idx = fl_idx;
        end
    end
    assign out_idx_ext = {{SLOT_W{1'b0}}, out_idx};

    always_comb begin
        n_strobe  = i_cmd.run_fetch || i_cmd.run_dirty || i_cmd.run_flush;
        n_slot    = out_idx_ext[SLOT_W-1:0];
        n_matched = 1'b0;
        n_load    = 1'b0;
        n_wb      = 1'b0;
        n_wb_file = '0;
        n_wb_page = '0;
        n_last    = 1'b1;
        if (i_cmd.run_fetch) begin
            n_matched = hit_any;
            n_load    = !hit_any;
            n_wb      = wb_victim;
            if (wb_victim) begin
                n_wb_file = rd_file_ext[FILE_W-1:0];
                n_wb_page = rd_page;
            end
        end else if (i_cmd.run_dirty) begin
            n_matched = hit_any;
        end else if (i_cmd.run_flush) begin
            n_wb   = |r_dirty;
            n_last = o_status.flush_last;
            if (|r_dirty) begin
                n_wb_file = rd_file_ext[FILE_W-1:0];
                n_wb_page = rd_page;
            end
        end
    end

    // Control state: valid and dirty marks, ranks and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rank[i] <= IW'(i);
            end
        end else begin
            r_strobe <= n_strobe;
            if (i_cmd.run_fetch) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (IW'(i) == target_idx) begin
                        r_rank[i] <= NEWEST;
                    end else if (r_rank[i] > target_rank) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end
                if (!hit_any) begin
                    r_valid[target_idx] <= 1'b1;
                    r_dirty[target_idx] <= 1'b0;
                end
            end
            if (i_cmd.run_dirty && hit_any) begin
                r_dirty[hit_idx] <= 1'b1;
            end
            if (i_cmd.run_flush) begin
                r_dirty <= fl_rem;
            end
        end
    end

    // Tags, the captured request and the result words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hit      <= hit_vec;
            r_req_file <= in_file;
            r_req_page <= i_page_number;
        end
        if (i_cmd.run_fetch && !hit_any) begin
            r_file[target_idx] <= r_req_file;
            r_page[target_idx] <= r_req_page;
        end
        r_slot    <= n_slot;
        r_matched <= n_matched;
        r_load    <= n_load;
        r_wb      <= n_wb;
        r_wb_file <= n_wb_file;
        r_wb_page <= n_wb_page;
        r_last    <= n_last;
    end

    assign o_strobe         = r_strobe;
    assign o_slot           = r_slot;
    assign o_matched        = r_matched;
    assign o_load_needed    = r_load;
    assign o_writeback      = r_wb;
    assign o_writeback_file = r_wb_file;
    assign o_writeback_page = r_wb_page;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run_fetch || i_cmd.run_dirty) |-> $onehot0(r_hit))
        else $error("more than one slot matched the request");

    a_one_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run_fetch && evict) |-> $onehot(rank_zero))
        else $error("no unique least recently used slot on eviction");

    a_wb_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_wb) |-> (r_wb_file == '0 && r_wb_page == '0))
        else $error("writeback fields set without a writeback");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run_flush && (|r_dirty)) |=> !r_dirty[$past(fl_idx)])
        else $error("flushed slot still marked dirty");
`endif

endmodule

`default_nettype wire

@@ src/page_buffer_lru_tag_controller.sv @@
// Top level of the page buffer LRU tag controller.
//
// A request word (action, file id, page number) is taken at a rising edge
// where start is high and busy is low. Each result word appears for exactly
// one cycle with o_strobe high; the receiver cannot hold it off, so the
// block never waits on the output side. o_last marks the final result word
// of a request.
// For a fetch or set-dirty request, the tags are compared in parallel
// against the request in the accept cycle, and the slot choice, rank
// update and result are done in the next. Its single result word shows
// in the cycle after that, and busy is low again then, so a new request
// can be taken while that result word shows.
// A flush emits one result word per dirty slot, one per cycle, lowest slot
// first, or a single word with o_writeback low when nothing is dirty.
// An unknown action is accepted and dropped with no result.
// Synchronous reset clears all valid and dirty marks and sets the rank of
// each slot to its index; the block can take a request right after reset.
`default_nettype none

module page_buffer_lru_tag_controller #(
    parameter int NUM_SLOTS    = pblru_pkg::NUM_SLOTS_DEF,
    parameter int FILE_ID_BITS = pblru_pkg::FILE_ID_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [pblru_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [pblru_pkg::FILE_W-1:0]    i_file_id,
    input  wire logic [pblru_pkg::PAGE_W-1:0]    i_page_number,
    output logic                                 o_strobe,
    output logic [pblru_pkg::SLOT_W-1:0]         o_slot,
    output logic                                 o_matched,
    output logic                                 o_load_needed,
    output logic                                 o_writeback,
    output logic [pblru_pkg::FILE_W-1:0]         o_writeback_file,
    output logic [pblru_pkg::PAGE_W-1:0]         o_writeback_page,
    output logic                                 o_last
);
    import pblru_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    pblru_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pblru_datapath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .FILE_ID_BITS (FILE_ID_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_file_id        (i_file_id),
        .i_page_number    (i_page_number),
        .o_strobe         (o_strobe),
        .o_slot           (o_slot),
        .o_matched        (o_matched),
        .o_load_needed    (o_load_needed),
        .o_writeback      (o_writeback),
        .o_writeback_file (o_writeback_file),
        .o_writeback_page (o_writeback_page),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire
